[src/assert_macros.svh]
// Assertion macros shared by the touch gesture classifier RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent property check, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Signal that must never be high outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `ASSERT_PROP(label, clk, rstn, !(expr), msg)
`else
`define ASSERT_PROP(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

[src/tgc_pkg.sv]
// Package for the touch gesture classifier: event and gesture codes,
// register indexes, reset values and default widths. No dependencies.
`timescale 1ns / 1ps

package tgc_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int FUNC_W    = 2;
    localparam int GESTURE_W = 3;
    localparam int CFG_IDX_W = 2;

    // event kinds carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_X      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_Y      = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

    localparam logic [GESTURE_W-1:0] G_NONE  = 3'd0;
    localparam logic [GESTURE_W-1:0] G_UP    = 3'd1;
    localparam logic [GESTURE_W-1:0] G_DOWN  = 3'd2;
    localparam logic [GESTURE_W-1:0] G_RIGHT = 3'd3;
    localparam logic [GESTURE_W-1:0] G_LEFT  = 3'd4;
    localparam logic [GESTURE_W-1:0] G_TAP   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_Y = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MS  = 2'd2;

    localparam int SWIPE_THRESH_RESET = 100;
    localparam int TAP_TIME_RESET     = 200;

    // button value meaning press; anything else releases
    localparam int BUTTON_PRESS = 1;

endpackage

[src/touch_gesture_classifier.sv]
// Top level of the touch gesture classifier: stream ports, config port.
// Depends on tgc_pkg, tgc_cfg_regs, tgc_tracker and tgc_out_buf.
`timescale 1ns / 1ps

// Takes one touch event beat per clock unless stalled (press/release, X, Y,
// 1 ms tick) and emits one gesture beat for every button release, which is
// written into the two-entry output buffer as the release is accepted. Touch
// state updates at the accepting edge, so events stream back to back with no
// bubbles. s_tready drops only while both entries are full under m_tready
// backpressure. Config writes are always accepted and take effect next cycle.
module touch_gesture_classifier #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT,
    parameter int TIMER_BITS = tgc_pkg::TIMER_BITS_DEFAULT,
    parameter int CFG_DATA_W = (COORD_BITS > TIMER_BITS) ? COORD_BITS : TIMER_BITS,
    parameter int S_DATA_W   = ((COORD_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [S_DATA_W-1:0]            s_tdata,   // event_value
    input  logic [tgc_pkg::FUNC_W-1:0]     s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DATA_W-1:0]            m_tdata,   // tap_x, tap_y
    output logic [tgc_pkg::GESTURE_W-1:0]  m_tuser,   // gesture
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data
);

    localparam int BUF_W = tgc_pkg::GESTURE_W + 2 * COORD_BITS;

    logic [COORD_BITS-1:0]          swipe_y_threshold;
    logic [COORD_BITS-1:0]          swipe_x_threshold;
    logic [TIMER_BITS-1:0]          tap_ticks;
    logic                           ev_accept;
    logic                           res_valid;
    logic [tgc_pkg::GESTURE_W-1:0]  res_gesture;
    logic [COORD_BITS-1:0]          res_x;
    logic [COORD_BITS-1:0]          res_y;
    logic                           can_push;
    logic [BUF_W-1:0]               buf_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_push;
    assign ev_accept = s_tvalid && s_tready;

    tgc_cfg_regs #(
        .COORD_BITS (COORD_BITS),
        .TIMER_BITS (TIMER_BITS),
        .CFG_DATA_W (CFG_DATA_W)
    ) u_cfg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .wr_en             (cfg_valid && cfg_ready),
        .wr_index          (cfg_index),
        .wr_data           (cfg_data),
        .swipe_y_threshold (swipe_y_threshold),
        .swipe_x_threshold (swipe_x_threshold),
        .tap_ticks         (tap_ticks)
    );

    tgc_tracker #(
        .COORD_BITS (COORD_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_tracker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ev_accept         (ev_accept),
        .ev_func           (s_tuser),
        .ev_value          (s_tdata[COORD_BITS-1:0]),
        .swipe_y_threshold (swipe_y_threshold),
        .swipe_x_threshold (swipe_x_threshold),
        .tap_ticks         (tap_ticks),
        .res_valid         (res_valid),
        .res_gesture       (res_gesture),
        .res_x             (res_x),
        .res_y             (res_y)
    );

    tgc_out_buf #(
        .DATA_W (BUF_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data ({res_gesture, res_y, res_x}),
        .can_push  (can_push),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (buf_out)
    );

    assign m_tuser = buf_out[BUF_W-1 -: tgc_pkg::GESTURE_W];
    assign m_tdata = M_DATA_W'(buf_out[2*COORD_BITS-1:0]);

endmodule

[src/tgc_cfg_regs.sv]
// Configuration register file: swipe thresholds and tap time.
// Depends on tgc_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module tgc_cfg_regs #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT,
    parameter int TIMER_BITS = tgc_pkg::TIMER_BITS_DEFAULT,
    parameter int CFG_DATA_W = (COORD_BITS > TIMER_BITS) ? COORD_BITS : TIMER_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0]          wr_data,
    output logic [COORD_BITS-1:0]          swipe_y_threshold,
    output logic [COORD_BITS-1:0]          swipe_x_threshold,
    output logic [TIMER_BITS-1:0]          tap_ticks
);

    logic [COORD_BITS-1:0] swipe_y_reg;
    logic [COORD_BITS-1:0] swipe_x_reg;
    logic [TIMER_BITS-1:0] tap_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swipe_y_reg <= COORD_BITS'(tgc_pkg::SWIPE_THRESH_RESET);
            swipe_x_reg <= COORD_BITS'(tgc_pkg::SWIPE_THRESH_RESET);
            tap_ms_reg  <= TIMER_BITS'(tgc_pkg::TAP_TIME_RESET);
        end else if (wr_en) begin
            case (wr_index)
                tgc_pkg::REG_SWIPE_Y: swipe_y_reg <= wr_data[COORD_BITS-1:0];
                tgc_pkg::REG_SWIPE_X: swipe_x_reg <= wr_data[COORD_BITS-1:0];
                tgc_pkg::REG_TAP_MS:  tap_ms_reg  <= wr_data[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign swipe_y_threshold = swipe_y_reg;
    assign swipe_x_threshold = swipe_x_reg;
    assign tap_ticks         = tap_ms_reg;

endmodule

[src/tgc_tracker.sv]
// Touch state registers and gesture decision for one event beat.
// Depends on tgc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgc_tracker #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT,
    parameter int TIMER_BITS = tgc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ev_accept,
    input  logic [tgc_pkg::FUNC_W-1:0]     ev_func,
    input  logic [COORD_BITS-1:0]          ev_value,
    input  logic [COORD_BITS-1:0]          swipe_y_threshold,
    input  logic [COORD_BITS-1:0]          swipe_x_threshold,
    input  logic [TIMER_BITS-1:0]          tap_ticks,
    output logic                           res_valid,
    output logic [tgc_pkg::GESTURE_W-1:0]  res_gesture,
    output logic [COORD_BITS-1:0]          res_x,
    output logic [COORD_BITS-1:0]          res_y
);

    logic                  touching_reg, touching_next;
    logic [COORD_BITS-1:0] first_x_reg, first_x_next;
    logic [COORD_BITS-1:0] first_y_reg, first_y_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;

    logic                is_press;
    logic                is_release;
    logic signed [COORD_BITS:0] dy, dx;
    logic [COORD_BITS:0] mag_y, mag_x;

    assign is_press   = (ev_value == COORD_BITS'(tgc_pkg::BUTTON_PRESS));
    assign is_release = ev_accept && (ev_func == tgc_pkg::FUNC_BUTTON) && !is_press;

    assign dy    = $signed({1'b0, last_y_reg}) - $signed({1'b0, first_y_reg});
    assign dx    = $signed({1'b0, last_x_reg}) - $signed({1'b0, first_x_reg});
    assign mag_y = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
    assign mag_x = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);

    always_comb begin
        if (mag_y > {1'b0, swipe_y_threshold}) begin
            res_gesture = dy[COORD_BITS] ? tgc_pkg::G_UP : tgc_pkg::G_DOWN;
        end else if (mag_x > {1'b0, swipe_x_threshold}) begin
            res_gesture = dx[COORD_BITS] ? tgc_pkg::G_LEFT : tgc_pkg::G_RIGHT;
        end else if (elapsed_reg < tap_ticks) begin
            res_gesture = tgc_pkg::G_TAP;
        end else begin
            res_gesture = tgc_pkg::G_NONE;
        end
    end

    assign res_valid = is_release;
    assign res_x     = last_x_reg;
    assign res_y     = last_y_reg;

    always_comb begin
        touching_next = touching_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        elapsed_next  = elapsed_reg;
        if (ev_accept) begin
            case (ev_func)
                tgc_pkg::FUNC_BUTTON: begin
                    if (is_press) begin
                        touching_next = 1'b1;
                        elapsed_next  = '0;
                    end else begin
                        touching_next = 1'b0;
                        first_x_next  = '0;
                        first_y_next  = '0;
                        last_x_next   = '0;
                        last_y_next   = '0;
                        elapsed_next  = '1;
                    end
                end
                tgc_pkg::FUNC_X: begin
                    if (touching_reg) begin
                        if (first_x_reg == '0) first_x_next = ev_value;
                        last_x_next = ev_value;
                    end
                end
                tgc_pkg::FUNC_Y: begin
                    if (touching_reg) begin
                        if (first_y_reg == '0) first_y_next = ev_value;
                        last_y_next = ev_value;
                    end
                end
                default: begin
                    if (elapsed_reg != '1) elapsed_next = elapsed_reg + TIMER_BITS'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touching_reg <= 1'b0;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            elapsed_reg  <= '1;
        end else begin
            touching_reg <= touching_next;
            first_x_reg  <= first_x_next;
            first_y_reg  <= first_y_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    `ASSERT_PROP(a_release_clears, aclk, aresetn, is_release |=> (!touching_reg && elapsed_reg == '1), "release did not clear touch state")
    `ASSERT_PROP(a_press_restarts, aclk, aresetn, (ev_accept && ev_func == tgc_pkg::FUNC_BUTTON && is_press) |=> (touching_reg && elapsed_reg == '0), "press did not restart timer")
    `ASSERT_PROP(a_idle_no_points, aclk, aresetn, !touching_reg |-> (first_x_reg == '0 && last_x_reg == '0 && first_y_reg == '0 && last_y_reg == '0), "points held while not touching")

endmodule

[src/tgc_out_buf.sv]
// Two-entry result buffer (output register plus skid) for gesture beats.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgc_out_buf #(
    parameter int DATA_W = 27
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              can_push,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] main_data_reg, main_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              main_free;

    assign main_free = !main_valid_reg || m_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (main_free) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (m_ready) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign can_push = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    `ASSERT_PROP(a_skid_needs_main, aclk, aresetn, skid_valid_reg |-> main_valid_reg, "skid full while output empty")
    `ASSERT_NEVER(a_push_when_full, aclk, aresetn, push && skid_valid_reg, "beat pushed into full buffer")
    `ASSERT_PROP(a_stall_to_skid, aclk, aresetn, (push && main_valid_reg && !m_ready) |=> (skid_valid_reg && main_valid_reg), "stalled beat not kept in skid")

endmodule

[sim/tb_touch_gesture_classifier.sv]
// Self-checking testbench for touch_gesture_classifier: a directed table of expected
// gestures, then random strokes under several settings, checked by a local tracker.
// Depends on tgc_pkg and the touch_gesture_classifier RTL.
`timescale 1ns / 1ps

module tb_touch_gesture_classifier;

    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SEG_ITEMS   = 120;
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef struct packed {
        logic [tgc_pkg::GESTURE_W-1:0] gesture;
        logic [11:0]                   x;
        logic [11:0]                   y;
    } gesture_rec_t;

    typedef struct packed {
        logic [tgc_pkg::FUNC_W-1:0] func;
        logic [11:0]                value;
        logic                       typed;
        gesture_rec_t               want;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        {tgc_pkg::FUNC_BUTTON, 12'd0,    TYPED, tgc_pkg::G_NONE,  12'd0,    12'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd0,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd4095, PRED,  27'd0},
        {tgc_pkg::FUNC_Y,      12'd4095, PRED,  27'd0},
        {tgc_pkg::FUNC_Y,      12'd0,    PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd4095, TYPED, tgc_pkg::G_UP,    12'd4095, 12'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_Y,      12'd10,   PRED,  27'd0},
        {tgc_pkg::FUNC_Y,      12'd300,  PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd2,    TYPED, tgc_pkg::G_DOWN,  12'd0,    12'd300},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd10,   PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd111,  PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd0,    TYPED, tgc_pkg::G_RIGHT, 12'd111,  12'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd200,  PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd99,   PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd3,    TYPED, tgc_pkg::G_LEFT,  12'd99,   12'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd1,    PRED,  27'd0},
        {tgc_pkg::FUNC_X,      12'd50,   PRED,  27'd0},
        {tgc_pkg::FUNC_Y,      12'd60,   PRED,  27'd0},
        {tgc_pkg::FUNC_TICK,   12'd4095, PRED,  27'd0},
        {tgc_pkg::FUNC_BUTTON, 12'd0,    TYPED, tgc_pkg::G_TAP,   12'd50,   12'd60}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_DATA_W-1:0]            s_tdata = '0;
    logic [tgc_pkg::FUNC_W-1:0]     s_tuser = tgc_pkg::FUNC_BUTTON;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [M_DATA_W-1:0]            m_tdata;
    logic [tgc_pkg::GESTURE_W-1:0]  m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index = tgc_pkg::REG_SWIPE_Y;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;

    // tracker state
    logic        touching = 1'b0;
    logic [11:0] first_x = '0, first_y = '0, last_x = '0, last_y = '0;
    logic [15:0] elapsed = '1;
    logic [11:0] thr_y = 12'(tgc_pkg::SWIPE_THRESH_RESET);
    logic [11:0] thr_x = 12'(tgc_pkg::SWIPE_THRESH_RESET);
    logic [15:0] tap_ms = 16'(tgc_pkg::TAP_TIME_RESET);

    gesture_rec_t pending_gestures[$];
    int mismatches = 0;
    int sent = 0;
    int cycles = 0;
    int tx_idle_pct = 27;
    int rx_idle_pct = 47;

    touch_gesture_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // event_value
        .s_tuser   (s_tuser),   // func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // tap_x, tap_y
        .m_tuser   (m_tuser),   // gesture
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Advances the tracker by one event; returns 1 when a gesture is reported.
    function automatic bit track_touch(input logic [tgc_pkg::FUNC_W-1:0] func,
                                       input logic [11:0] val,
                                       output gesture_rec_t res);
        int dx, dy, adx, ady;
        bit fired;
        fired = 1'b0;
        res = '0;
        case (func)
            tgc_pkg::FUNC_BUTTON: begin
                if (val == 12'(tgc_pkg::BUTTON_PRESS)) begin
                    touching = 1'b1;
                    elapsed = '0;
                end else begin
                    dy = int'(last_y) - int'(first_y);
                    dx = int'(last_x) - int'(first_x);
                    ady = (dy < 0) ? -dy : dy;
                    adx = (dx < 0) ? -dx : dx;
                    if (ady > int'(thr_y))
                        res.gesture = (dy < 0) ? tgc_pkg::G_UP : tgc_pkg::G_DOWN;
                    else if (adx > int'(thr_x))
                        res.gesture = (dx > 0) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
                    else if (elapsed < tap_ms)
                        res.gesture = tgc_pkg::G_TAP;
                    else
                        res.gesture = tgc_pkg::G_NONE;
                    res.x = last_x;
                    res.y = last_y;
                    fired = 1'b1;
                    touching = 1'b0;
                    first_x = '0;
                    first_y = '0;
                    last_x = '0;
                    last_y = '0;
                    elapsed = '1;
                end
            end
            tgc_pkg::FUNC_X: begin
                if (touching) begin
                    if (first_x == '0)
                        first_x = val;
                    last_x = val;
                end
            end
            tgc_pkg::FUNC_Y: begin
                if (touching) begin
                    if (first_y == '0)
                        first_y = val;
                    last_y = val;
                end
            end
            default: begin
                if (elapsed != '1)
                    elapsed = elapsed + 16'd1;
            end
        endcase
        return fired;
    endfunction

    // Called at a falling edge; returns at a falling edge with tvalid still high.
    task automatic send_event(input logic [tgc_pkg::FUNC_W-1:0] func,
                              input logic [11:0] val,
                              input logic typed, input gesture_rec_t want);
        gesture_rec_t got;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_DATA_W'(val);
        do @(posedge aclk); while (!s_tready);
        if (track_touch(func, val, got))
            pending_gestures.push_back(typed ? want : got);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_plain(input logic [tgc_pkg::FUNC_W-1:0] func,
                              input logic [11:0] val);
        send_event(func, val, PRED, '0);
    endtask

    // Holds the sender until every expected gesture is back and the block is quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_gestures.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_regs(input logic [11:0] ty, input logic [11:0] tx,
                                input logic [15:0] tt);
        logic [tgc_pkg::CFG_IDX_W-1:0] idx [3] = '{tgc_pkg::REG_SWIPE_Y,
                                                   tgc_pkg::REG_SWIPE_X,
                                                   tgc_pkg::REG_TAP_MS};
        logic [CFG_DATA_W-1:0] val [3] = '{CFG_DATA_W'(ty), CFG_DATA_W'(tx), tt};
        for (int r = 0; r < 3; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= val[r];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[r])
                tgc_pkg::REG_SWIPE_Y: thr_y = val[r][11:0];
                tgc_pkg::REG_SWIPE_X: thr_x = val[r][11:0];
                default:              tap_ms = val[r];
            endcase
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Coordinate just around the threshold distance from start, either direction.
    function automatic logic [11:0] offset_coord(input logic [11:0] start,
                                                 input logic [11:0] thr);
        int d, v;
        d = int'(thr) + int'($urandom_range(0, 3)) - 1;
        if ($urandom_range(0, 1))
            d = -d;
        v = int'(start) + d;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    function automatic logic [11:0] rand_coord();
        return ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
    endfunction

    task automatic touch_stroke();
        logic [11:0] x0, y0, rel;
        int n;
        send_plain(tgc_pkg::FUNC_BUTTON, 12'(tgc_pkg::BUTTON_PRESS));
        x0 = rand_coord();
        y0 = rand_coord();
        if ($urandom_range(0, 1)) begin
            send_plain(tgc_pkg::FUNC_X, x0);
            send_plain(tgc_pkg::FUNC_Y, y0);
        end else begin
            send_plain(tgc_pkg::FUNC_Y, y0);
            send_plain(tgc_pkg::FUNC_X, x0);
        end
        if (tap_ms <= 16'd40 && $urandom_range(0, 1))
            n = int'(tap_ms) + int'($urandom_range(0, 2)) - 1;
        else
            n = $urandom_range(0, 3);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                send_plain($urandom_range(0, 1) ? tgc_pkg::FUNC_X : tgc_pkg::FUNC_Y,
                           rand_coord());
            send_plain(tgc_pkg::FUNC_TICK, 12'($urandom_range(0, 4095)));
        end
        if ($urandom_range(0, 9) == 0)
            send_plain(tgc_pkg::FUNC_BUTTON, 12'(tgc_pkg::BUTTON_PRESS));
        case ($urandom_range(0, 3))
            1: send_plain(tgc_pkg::FUNC_X, offset_coord(x0, thr_x));
            2: send_plain(tgc_pkg::FUNC_Y, offset_coord(y0, thr_y));
            3: begin
                send_plain(tgc_pkg::FUNC_X, offset_coord(x0, thr_x));
                send_plain(tgc_pkg::FUNC_Y, offset_coord(y0, thr_y));
            end
            default: ;
        endcase
        rel = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 4095));
        if (rel == 12'(tgc_pkg::BUTTON_PRESS))
            rel = 12'd0;
        send_plain(tgc_pkg::FUNC_BUTTON, rel);
    endtask

    task automatic event_noise();
        logic [tgc_pkg::FUNC_W-1:0] f;
        logic [11:0] v;
        repeat ($urandom_range(1, 4)) begin
            f = tgc_pkg::FUNC_W'($urandom_range(0, 3));
            v = 12'($urandom_range(0, 4095));
            if (f == tgc_pkg::FUNC_BUTTON && $urandom_range(0, 2) == 0)
                v = 12'(tgc_pkg::BUTTON_PRESS);
            send_plain(f, v);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        gesture_rec_t exp_g;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_gestures.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected gesture beat: g=%0d x=%0d y=%0d",
                             m_tuser, m_tdata[11:0], m_tdata[23:12]);
            end else begin
                exp_g = pending_gestures.pop_front();
                if (m_tuser !== exp_g.gesture || m_tdata[11:0] !== exp_g.x ||
                    m_tdata[23:12] !== exp_g.y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("gesture mismatch: expected g=%0d x=%0d y=%0d, got g=%0d x=%0d y=%0d",
                                 exp_g.gesture, exp_g.x, exp_g.y,
                                 m_tuser, m_tdata[11:0], m_tdata[23:12]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_touch_gesture_classifier: FAIL");
            $finish;
        end
    end

    initial begin
        int seg_end;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_event(SCRIPT[i].func, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);

        for (int seg = 1; seg <= 6; seg++) begin
            drain();
            tx_idle_pct = (seg <= 2) ? 27 : (seg <= 4) ? 47 : 0;
            rx_idle_pct = (seg <= 2) ? 47 : (seg <= 4) ? 27 : 0;
            case (seg)
                1: program_regs(12'd0, 12'd0, 16'd0);
                2: program_regs(12'd4095, 12'd4095, 16'd65535);
                3: program_regs(12'd20, 12'd30, 16'd6);
                5: program_regs(12'd300, 12'd5, 16'd3);
                default: program_regs(12'($urandom_range(0, 150)),
                                      12'($urandom_range(0, 150)),
                                      16'($urandom_range(0, 12)));
            endcase
            seg_end = sent + SEG_ITEMS;
            while (sent < seg_end) begin
                if ($urandom_range(0, 99) < 80)
                    touch_stroke();
                else
                    event_noise();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_gestures.size() == 0)
            $display("tb_touch_gesture_classifier: PASS");
        else
            $display("tb_touch_gesture_classifier: FAIL");
        $finish;
    end

endmodule
